### sv/qerr_pkg.sv
// Package for the quadratic exact root reducer.
// Holds the sequencer state codes and the result status codes.
// No dependencies.
`default_nettype none
package qerr_pkg;

    // Result status codes
    localparam logic [1:0] ST_DEGEN  = 2'd0;
    localparam logic [1:0] ST_NOREAL = 2'd1;
    localparam logic [1:0] ST_RATNL  = 2'd2;
    localparam logic [1:0] ST_SURD   = 2'd3;

    // Sequencer states, one-hot
    typedef enum logic [27:0] {
        S_IDLE     = 28'd1 << 0,
        S_MUL1     = 28'd1 << 1,
        S_MUL2     = 28'd1 << 2,
        S_DISC     = 28'd1 << 3,
        S_SQRT     = 28'd1 << 4,
        S_SQMUL    = 28'd1 << 5,
        S_SQCHK    = 28'd1 << 6,
        S_RAT_SET  = 28'd1 << 7,
        S_GCD      = 28'd1 << 8,
        S_GCD_STEP = 28'd1 << 9,
        S_DWAIT    = 28'd1 << 10,
        S_RAT_DIVN = 28'd1 << 11,
        S_RAT_DIVD = 28'd1 << 12,
        S_RAT_NEXT = 28'd1 << 13,
        S_TD_HEAD  = 28'd1 << 14,
        S_TD_HCHK  = 28'd1 << 15,
        S_TD_QMUL  = 28'd1 << 16,
        S_TD_INNER = 28'd1 << 17,
        S_TD_ICHK  = 28'd1 << 18,
        S_RAD1     = 28'd1 << 19,
        S_RAD2     = 28'd1 << 20,
        S_RAD3     = 28'd1 << 21,
        S_IRR_G2   = 28'd1 << 22,
        S_IRR_DIV1 = 28'd1 << 23,
        S_IRR_DIV2 = 28'd1 << 24,
        S_IRR_DIV3 = 28'd1 << 25,
        S_IRR_DIV4 = 28'd1 << 26,
        S_FINISH   = 28'd1 << 27
    } t_state;

endpackage
`default_nettype wire

### sv/quadratic_exact_root_reducer_unit.sv
// Quadratic exact root reducer top: sequencer, shared multiplier and divider; uses qerr_pkg.
// When a = 0 or D < 0 the sequencer goes straight to the result; otherwise it forms the integer
// square root of D bit by bit, reduces rational roots by gcd and division, and for a surd runs
// trial division by each divisor up to sqrt(D) to split off the square factor of D.
// Throughput: one transaction at a time, next input accepted the cycle after the result loads.
// Reset is synchronous, active low, and clears the sequencer and output valid.
`default_nettype none
module quadratic_exact_root_reducer_unit #(
    parameter int unsigned COEF_WIDTH = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // coef_a, coef_b, coef_c (COEF_WIDTH bits each), zero pad to bytes
    input  wire logic [((3*COEF_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // first_num[17:0], first_den[34:18], second_num[52:35], second_den[69:53],
    // surd_coef[86:70], surd_radicand[119:87]
    output logic [119:0]               o_m_axis_tdata,
    // status[1:0]
    output logic [1:0]                 o_m_axis_tuser
);
    import qerr_pkg::*;

    localparam int unsigned W   = COEF_WIDTH;
    localparam int unsigned AW  = W + 2;
    localparam int unsigned DW  = 2 * W + 1;
    localparam int unsigned PW  = 2 * AW;
    localparam int unsigned XW  = (DW + 2 > 34) ? DW + 2 : 34;
    localparam int unsigned SCW = $clog2(W + 2);

    t_state r_state;
    t_state r_ret;
    t_state r_gret;

    logic signed [AW-1:0] r_a, r_b, r_c;
    logic signed [PW-1:0] r_prod, r_bb;
    logic [DW-1:0]        r_d, r_den, r_x, r_y, r_g, r_n, r_p, r_q;
    logic [DW:0]          r_sv, r_sr, r_sbit;
    logic [SCW-1:0]       r_scnt;
    logic signed [DW:0]   r_num0, r_num1;
    logic                 r_idx, r_e;

    logic [1:0]           r_st;
    logic signed [XW-1:0] r_fn, r_sn;
    logic [XW-1:0]        r_fd, r_sd, r_sc, r_rad;

    logic                 r_ovalid;
    logic [119:0]         r_odata;
    logic [1:0]           r_ouser;

    logic signed [AW-1:0] w_ma, w_mb;
    logic signed [AW-1:0] w_ina, w_inb, w_inc;
    logic signed [PW+1:0] w_dfull;
    logic [DW:0]          w_trial;
    logic signed [DW:0]   w_num, w_negb;
    logic [DW-1:0]        w_num_abs, w_b_abs;
    logic signed [DW:0]   w_quo_s;
    logic                 w_dstart;
    logic [DW-1:0]        w_dvd, w_dvs;
    logic                 w_dbusy;
    logic [DW-1:0]        w_quo, w_rem;

    // Sign-extend the input fields
    always_comb begin
        w_ina = AW'($signed(i_s_axis_tdata[W-1:0]));
        w_inb = AW'($signed(i_s_axis_tdata[2*W-1:W]));
        w_inc = AW'($signed(i_s_axis_tdata[3*W-1:2*W]));
    end

    // Shared multiplier operand select; product registered every cycle
    always_comb begin
        case (r_state)
            S_MUL1: begin
                w_ma = r_b;
                w_mb = r_b;
            end
            S_MUL2: begin
                w_ma = r_a;
                w_mb = r_c;
            end
            S_SQMUL: begin
                w_ma = $signed({1'b0, r_sr[W:0]});
                w_mb = $signed({1'b0, r_sr[W:0]});
            end
            default: begin
                w_ma = $signed({1'b0, r_q[W:0]});
                w_mb = $signed({1'b0, r_p[W:0]});
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // Helper values for the datapath
    always_comb begin
        w_dfull   = (PW + 2)'(r_bb) - ((PW + 2)'(r_prod) <<< 2);
        w_trial   = r_sr + r_sbit;
        w_num     = r_idx ? r_num1 : r_num0;
        w_num_abs = w_num[DW] ? DW'(-w_num) : w_num[DW-1:0];
        w_b_abs   = r_b[AW-1] ? DW'(-r_b) : DW'(r_b);
        w_negb    = -((DW + 1)'(r_b));
        w_quo_s   = $signed({1'b0, w_quo});
    end

    // Divider start and operand select
    always_comb begin
        w_dstart = 1'b0;
        w_dvd    = r_x;
        w_dvs    = r_y;
        case (r_state)
            S_GCD: begin
                w_dstart = (r_y != '0);
            end
            S_RAT_DIVN: begin
                w_dstart = 1'b1;
                w_dvd    = w_num_abs;
                w_dvs    = r_g;
            end
            S_RAT_DIVD, S_IRR_DIV2: begin
                w_dstart = 1'b1;
                w_dvd    = r_den;
                w_dvs    = r_g;
            end
            S_TD_HEAD, S_TD_INNER: begin
                w_dstart = 1'b1;
                w_dvd    = r_n;
                w_dvs    = r_p;
            end
            S_RAD1: begin
                w_dstart = 1'b1;
                w_dvd    = r_d;
                w_dvs    = r_q;
            end
            S_RAD2: begin
                w_dstart = 1'b1;
                w_dvd    = w_quo;
                w_dvs    = r_q;
            end
            S_IRR_DIV1: begin
                w_dstart = 1'b1;
                w_dvd    = w_b_abs;
                w_dvs    = r_g;
            end
            S_IRR_DIV3: begin
                w_dstart = 1'b1;
                w_dvd    = r_q;
                w_dvs    = r_g;
            end
            default: begin
                w_dstart = 1'b0;
            end
        endcase
    end

    qerr_divider #(
        .DW(DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_dbusy),
        .o_quo      (w_quo),
        .o_rem      (w_rem)
    );

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_gret   <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: r_state <= S_MUL2;
                S_MUL2: r_state <= S_DISC;
                S_DISC: begin
                    if (r_a == '0 || w_dfull < 0) begin
                        r_state <= S_FINISH;
                    end else begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (r_scnt == '0) begin
                        r_state <= S_SQMUL;
                    end
                end
                S_SQMUL: r_state <= S_SQCHK;
                S_SQCHK: begin
                    if ($unsigned(r_prod) == PW'(r_d)) begin
                        r_state <= S_RAT_SET;
                    end else begin
                        r_state <= S_TD_HEAD;
                    end
                end
                S_RAT_SET: begin
                    if (w_num == '0) begin
                        if (r_idx) begin
                            r_state <= S_FINISH;
                        end
                    end else begin
                        r_gret  <= S_RAT_DIVN;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_y == '0) begin
                        r_state <= r_gret;
                    end else begin
                        r_ret   <= S_GCD_STEP;
                        r_state <= S_DWAIT;
                    end
                end
                S_GCD_STEP: r_state <= S_GCD;
                S_DWAIT: begin
                    if (!w_dbusy) begin
                        r_state <= r_ret;
                    end
                end
                S_RAT_DIVN: begin
                    r_ret   <= S_RAT_DIVD;
                    r_state <= S_DWAIT;
                end
                S_RAT_DIVD: begin
                    r_ret   <= S_RAT_NEXT;
                    r_state <= S_DWAIT;
                end
                S_RAT_NEXT: begin
                    r_state <= r_idx ? S_FINISH : S_RAT_SET;
                end
                S_TD_HEAD: begin
                    r_ret   <= S_TD_HCHK;
                    r_state <= S_DWAIT;
                end
                S_TD_HCHK: begin
                    if (r_p > w_quo) begin
                        r_state <= S_RAD1;
                    end else if (w_rem == '0) begin
                        r_state <= r_e ? S_TD_QMUL : S_TD_INNER;
                    end else begin
                        r_state <= S_TD_HEAD;
                    end
                end
                S_TD_QMUL: r_state <= S_TD_INNER;
                S_TD_INNER: begin
                    r_ret   <= S_TD_ICHK;
                    r_state <= S_DWAIT;
                end
                S_TD_ICHK: begin
                    if (w_rem == '0) begin
                        r_state <= r_e ? S_TD_QMUL : S_TD_INNER;
                    end else begin
                        r_state <= S_TD_HEAD;
                    end
                end
                S_RAD1: begin
                    r_ret   <= S_RAD2;
                    r_state <= S_DWAIT;
                end
                S_RAD2: begin
                    r_ret   <= S_RAD3;
                    r_state <= S_DWAIT;
                end
                S_RAD3: begin
                    r_gret  <= S_IRR_G2;
                    r_state <= S_GCD;
                end
                S_IRR_G2: begin
                    r_gret  <= S_IRR_DIV1;
                    r_state <= S_GCD;
                end
                S_IRR_DIV1: begin
                    r_ret   <= S_IRR_DIV2;
                    r_state <= S_DWAIT;
                end
                S_IRR_DIV2: begin
                    r_ret   <= S_IRR_DIV3;
                    r_state <= S_DWAIT;
                end
                S_IRR_DIV3: begin
                    r_ret   <= S_IRR_DIV4;
                    r_state <= S_DWAIT;
                end
                S_IRR_DIV4: r_state <= S_FINISH;
                S_FINISH: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                // Normalize so that a is not negative
                if (w_ina < 0) begin
                    r_a <= -w_ina;
                    r_b <= -w_inb;
                    r_c <= -w_inc;
                end else begin
                    r_a <= w_ina;
                    r_b <= w_inb;
                    r_c <= w_inc;
                end
            end
            S_MUL2: begin
                r_bb <= r_prod;
            end
            S_DISC: begin
                r_fn  <= '0;
                r_fd  <= '0;
                r_sn  <= '0;
                r_sd  <= '0;
                r_sc  <= '0;
                r_rad <= '0;
                r_idx <= 1'b0;
                if (r_a == '0) begin
                    r_st <= ST_DEGEN;
                end else if (w_dfull < 0) begin
                    r_st <= ST_NOREAL;
                end else begin
                    r_d    <= w_dfull[DW-1:0];
                    r_den  <= DW'(r_a) << 1;
                    r_sv   <= (DW + 1)'(w_dfull[DW-1:0]);
                    r_sr   <= '0;
                    r_sbit <= (DW + 1)'(1) << (2 * W);
                    r_scnt <= SCW'(W);
                end
            end
            S_SQRT: begin
                // One bit of the integer square root per cycle
                if (r_sv >= w_trial) begin
                    r_sv <= r_sv - w_trial;
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
                r_scnt <= r_scnt - 1'b1;
            end
            S_SQCHK: begin
                if ($unsigned(r_prod) == PW'(r_d)) begin
                    r_st   <= ST_RATNL;
                    r_num0 <= w_negb + $signed({1'b0, r_sr[DW-1:0]});
                    r_num1 <= w_negb - $signed({1'b0, r_sr[DW-1:0]});
                end else begin
                    r_st <= ST_SURD;
                    r_n  <= r_d;
                    r_p  <= DW'(2);
                    r_q  <= DW'(1);
                    r_e  <= 1'b0;
                end
            end
            S_RAT_SET: begin
                if (w_num == '0) begin
                    // Zero numerator reads as 0/1
                    if (r_idx) begin
                        r_sn <= '0;
                        r_sd <= XW'(1);
                    end else begin
                        r_fn  <= '0;
                        r_fd  <= XW'(1);
                        r_idx <= 1'b1;
                    end
                end else begin
                    r_x <= w_num_abs;
                    r_y <= r_den;
                end
            end
            S_GCD: begin
                if (r_y == '0) begin
                    r_g <= r_x;
                end
            end
            S_GCD_STEP: begin
                r_x <= r_y;
                r_y <= w_rem;
            end
            S_RAT_DIVD: begin
                if (r_idx) begin
                    r_sn <= XW'(w_num[DW] ? -w_quo_s : w_quo_s);
                end else begin
                    r_fn <= XW'(w_num[DW] ? -w_quo_s : w_quo_s);
                end
            end
            S_RAT_NEXT: begin
                if (r_idx) begin
                    r_sd <= XW'(w_quo);
                end else begin
                    r_fd  <= XW'(w_quo);
                    r_idx <= 1'b1;
                end
            end
            S_TD_HCHK: begin
                if (r_p <= w_quo) begin
                    if (w_rem == '0) begin
                        r_n <= w_quo;
                        r_e <= ~r_e;
                    end else begin
                        r_p <= r_p + 1'b1;
                    end
                end
            end
            S_TD_QMUL: begin
                r_q <= r_prod[DW-1:0];
            end
            S_TD_ICHK: begin
                if (w_rem == '0) begin
                    r_n <= w_quo;
                    r_e <= ~r_e;
                end else begin
                    r_p <= r_p + 1'b1;
                    r_e <= 1'b0;
                end
            end
            S_RAD3: begin
                r_rad <= XW'(w_quo);
                r_x   <= w_b_abs;
                r_y   <= r_q;
            end
            S_IRR_G2: begin
                r_x <= r_g;
                r_y <= r_den;
            end
            S_IRR_DIV2: begin
                r_fn <= XW'(r_b[AW-1] ? w_quo_s : -w_quo_s);
            end
            S_IRR_DIV3: begin
                r_fd <= XW'(w_quo);
            end
            S_IRR_DIV4: begin
                r_sc <= XW'(w_quo);
            end
            S_FINISH: begin
                if (!r_ovalid || i_m_axis_tready) begin
                    r_ouser <= r_st;
                    r_odata <= {r_rad[32:0], r_sc[16:0], r_sd[16:0], r_sn[17:0],
                                r_fd[16:0], r_fn[17:0]};
                end
            end
            default: begin
                r_e <= r_e;
            end
        endcase
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
    assign o_m_axis_tuser  = r_ouser;
endmodule
`default_nettype wire

### sv/qerr_divider.sv
// Shared unsigned restoring divider, one quotient bit per cycle.
// Gives quotient and remainder; used for gcd, trial division and reduction.
// No package dependencies.
`default_nettype none
module qerr_divider #(
    parameter int unsigned DW = 33
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [DW-1:0] i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_busy,
    output logic [DW-1:0]      o_quo,
    output logic [DW-1:0]      o_rem
);
    localparam int unsigned CW = $clog2(DW + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [DW-1:0] r_div;
    logic [DW:0]   w_sh;
    logic [DW:0]   w_diff;
    logic          w_ge;

    // Shift in the next dividend bit and trial-subtract
    always_comb begin
        w_sh   = {r_rem, r_quo[DW-1]};
        w_ge   = (w_sh >= {1'b0, r_div});
        w_diff = w_sh - {1'b0, r_div};
    end

    // Control: count down the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Datapath: partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

### sim/tb_quadratic_exact_root_reducer_unit.sv
// Testbench for quadratic_exact_root_reducer_unit: directed and random coefficient sets,
// a built-in root predictor and an in-order scoreboard of expected roots.
// Depends on qerr_pkg and the RTL of the block.
`default_nettype none
module tb_quadratic_exact_root_reducer_unit;
    import qerr_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic [17:0] first_num;
        logic [16:0] first_den;
        logic [17:0] second_num;
        logic [16:0] second_den;
        logic [16:0] surd_coef;
        logic [32:0] surd_radicand;
    } t_roots;

    // Exact integer square root by bit-wise build-up
    function automatic longint isqrt64(longint v);
        longint s;
        s = 0;
        for (int k = 20; k >= 0; k--) begin
            if ((s | (64'sd1 << k)) * (s | (64'sd1 << k)) <= v) s = s | (64'sd1 << k);
        end
        return s;
    endfunction

    function automatic longint gcd64(longint x, longint y);
        longint t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Work out the roots of one coefficient set
    function automatic t_roots solve_roots(logic [15:0] ra, logic [15:0] rb, logic [15:0] rc);
        t_roots res;
        longint a, b, c, d, den, s, n, q, r, p, g, nm;
        int e;
        res = '0;
        a = $signed(ra);
        b = $signed(rb);
        c = $signed(rc);
        if (a == 0) return res;
        if (a < 0) begin
            a = -a;
            b = -b;
            c = -c;
        end
        d = b * b - 4 * a * c;
        if (d < 0) begin
            res.status = ST_NOREAL;
            return res;
        end
        den = 2 * a;
        s = isqrt64(d);
        if (s * s == d) begin
            res.status = ST_RATNL;
            nm = -b + s;
            if (nm == 0) begin
                res.first_den = 17'd1;
            end else begin
                g = gcd64(abs64(nm), den);
                res.first_num = 18'(nm / g);
                res.first_den = 17'(den / g);
            end
            nm = -b - s;
            if (nm == 0) begin
                res.second_den = 17'd1;
            end else begin
                g = gcd64(abs64(nm), den);
                res.second_num = 18'(nm / g);
                res.second_den = 17'(den / g);
            end
        end else begin
            // Split D into q*q times a square-free part
            n = d;
            q = 1;
            r = 1;
            for (p = 2; p <= n / p; p++) begin
                e = 0;
                while (n % p == 0) begin
                    n = n / p;
                    e++;
                    if (e == 2) begin
                        q = q * p;
                        e = 0;
                    end
                end
                if (e == 1) r = r * p;
            end
            if (n > 1) r = r * n;
            g = gcd64(gcd64(abs64(b), q), den);
            res.status = ST_SURD;
            res.first_num = 18'(-b / g);
            res.first_den = 17'(den / g);
            res.surd_coef = 17'(q / g);
            res.surd_radicand = 33'(r);
        end
        return res;
    endfunction

    class root_scoreboard;
        t_roots pending[$];
        int     mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void note_coefs(logic [47:0] data);
            pending.insert(pending.size(), solve_roots(data[15:0], data[31:16], data[47:32]));
        endfunction

        function void flag(string what, longint unsigned want, longint unsigned got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d, got %0d", what, want, got);
        endfunction

        function void check_result(logic [1:0] status, logic [119:0] data);
            t_roots want;
            if (pending.size() == 0) begin
                flag("unexpected transaction", 0, status);
                return;
            end
            want = pending.pop_front();
            if (status !== want.status) flag("status", want.status, status);
            if (data[17:0] !== want.first_num) flag("first_num", want.first_num, data[17:0]);
            if (data[34:18] !== want.first_den) flag("first_den", want.first_den, data[34:18]);
            if (data[52:35] !== want.second_num)
                flag("second_num", want.second_num, data[52:35]);
            if (data[69:53] !== want.second_den)
                flag("second_den", want.second_den, data[69:53]);
            if (data[86:70] !== want.surd_coef) flag("surd_coef", want.surd_coef, data[86:70]);
            if (data[119:87] !== want.surd_radicand)
                flag("surd_radicand", want.surd_radicand, data[119:87]);
        endfunction
    endclass

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [119:0] m_tdata;
    logic [1:0]   m_tuser;
    bit           quiet;
    int           holdoff;
    root_scoreboard sb;

    quadratic_exact_root_reducer_unit #(.COEF_WIDTH(16)) u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Check every accepted result transaction
    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end

    // Drive receiver ready: random stalls, or a counted hold-off on request
    always @(negedge clk) begin
        if (holdoff > 0) begin
            m_tready = 1'b0;
            holdoff--;
        end else begin
            m_tready = quiet ? 1'b1 : ($urandom_range(99) >= 11);
        end
    end

    // Offer one coefficient set and wait for acceptance
    task automatic send_coefs(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        while (!quiet && $urandom_range(99) < 11) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {c, b, a};
        do @(posedge clk); while (!s_tready);
        sb.note_coefs(s_tdata);
        @(negedge clk);
    endtask

    task automatic send_random();
        int pick;
        logic [15:0] a, b, c;
        pick = $urandom_range(99);
        if (pick < 70) begin
            // small coefficients keep trial division short
            a = 16'($signed($urandom_range(80)) - 40);
            b = 16'($signed($urandom_range(80)) - 40);
            c = 16'($signed($urandom_range(80)) - 40);
        end else if (pick < 85) begin
            // large a and c of one sign: discriminant never positive
            a = 16'($urandom_range(32767, 16384));
            c = 16'($urandom_range(32767, 16384));
            b = 16'($urandom);
            if ($urandom_range(1)) begin
                a = -a;
                c = -c;
            end
        end else begin
            // c zero: discriminant is b squared, a perfect square
            a = 16'($urandom);
            b = 16'($urandom);
            c = 16'd0;
        end
        send_coefs(a, b, c);
    endtask

    initial begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        quiet = 1'b0;
        holdoff = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: degenerate, each class, zero discriminant, zero numerator, extremes
        send_coefs(16'd0, 16'd5, -16'sd7);
        send_coefs(16'd1, 16'd0, 16'd1);
        send_coefs(16'd1, -16'sd3, 16'd2);
        send_coefs(16'd1, 16'd2, 16'd1);
        send_coefs(16'd2, 16'd0, 16'd0);
        send_coefs(16'd1, 16'd1, -16'sd1);
        send_coefs(16'd2, 16'd4, -16'sd4);
        send_coefs(-16'sd1, 16'd3, 16'd1);
        send_coefs(16'd1, 16'd0, 16'h8000);
        send_coefs(16'd1, 16'h8000, 16'd0);
        send_coefs(16'h7fff, 16'h7fff, 16'd0);
        send_coefs(16'h8000, 16'd0, 16'd0);
        send_coefs(16'h8000, 16'h8000, 16'h8000);
        send_coefs(16'h7fff, 16'h8000, 16'h7fff);
        send_coefs(16'h8000, 16'h7fff, 16'h8000);
        send_coefs(16'hffff, 16'hffff, 16'hffff);
        send_coefs(16'h8000, 16'h7fff, 16'd0);

        // Long hold-off on the result side while quick no-real inputs keep coming
        holdoff = 300;
        for (int i = 0; i < 4; i++) send_coefs(16'd1, 16'(i), 16'd100);

        // Pause the sender until the pipeline drains
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);

        quiet = 1'b1;
        for (int i = 0; i < 30; i++) send_random();
        quiet = 1'b0;
        for (int i = 0; i < 66; i++) send_random();
        s_tvalid = 1'b0;

        while (sb.pending.size() != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Guard against a hung block
    initial begin
        #400_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
